// ===== design/pdt_pkg.sv =====
package pdt_pkg;

    // Result kind codes (m_tuser)
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [7:0] DELIM_RESET = 8'h24;  // '$'
    localparam logic [7:0] END_BYTE    = 8'h00;

    // Which result the datapath builds when told to emit
    typedef enum logic [2:0] {
        SEL_DATA_DELIM = 3'd0,  // leftover delimiter as data
        SEL_DATA_BYTE  = 3'd1,  // input byte as data
        SEL_KEY_BYTE   = 3'd2,  // held keyword byte on close
        SEL_EMPTY      = 3'd3,  // empty keyword
        SEL_DUMP_DELIM = 3'd4,  // delimiter of an unclosed keyword at end
        SEL_DUMP_KEY   = 3'd5,  // held byte of an unclosed keyword at end
        SEL_END        = 3'd6   // end of string
    } out_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     pend_inc;
        logic     pend_dec;
        logic     pend_clr;
        logic     key_open;
        logic     key_close;
        logic     append_delim;
        logic     append_byte;
        logic     idx_clr;
        logic     idx_inc;
        logic     emit;
        logic     emit_last;
        out_sel_t sel;
        logic     clear_all;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_delim;
        logic is_zero;
        logic pend_zero;
        logic pend_one;
        logic pend_two;
        logic in_key;
        logic key_empty;
        logic idx_last;
        logic idx_two;
        logic out_free;
    } status_t;

endpackage

// ===== design/pdt_datapath.sv =====
module pdt_datapath #(
    parameter int KEY_MAX = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic [7:0]       s_tdata,
    input  pdt_pkg::cmd_t    cmd,
    output pdt_pkg::status_t st,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam int LW = $clog2(KEY_MAX + 1);
    localparam int AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int IW = (LW > 2) ? LW : 2;

    logic [7:0]    delim_reg;
    logic [7:0]    byte_reg;
    logic [1:0]    pend_reg, pend_next;
    logic [LW-1:0] key_len_reg, key_len_next;
    logic          in_key_reg, in_key_next;
    logic          data_open_reg, data_open_next;
    logic          seen_reg, seen_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic [7:0]    key_mem [KEY_MAX];
    logic [7:0]    rdata_reg;

    logic          m_tvalid_reg;
    logic [1:0]    kind_reg;
    logic [7:0]    value_reg;
    logic          new_reg, last_reg, found_reg, trunc_reg;

    logic          app;
    logic [7:0]    app_data;
    logic          key_full;
    logic [1:0]    o_kind;
    logic [7:0]    o_value;
    logic          o_new, o_found, o_trunc;

    assign app      = cmd.append_delim | cmd.append_byte;
    assign app_data = cmd.append_delim ? delim_reg : byte_reg;
    assign key_full = (key_len_reg == LW'(KEY_MAX));

    // Status toward the controller
    always_comb begin
        st.is_delim  = (byte_reg != pdt_pkg::END_BYTE) && (byte_reg == delim_reg);
        st.is_zero   = (byte_reg == pdt_pkg::END_BYTE);
        st.pend_zero = (pend_reg == 2'd0);
        st.pend_one  = (pend_reg == 2'd1);
        st.pend_two  = (pend_reg == 2'd2);
        st.in_key    = in_key_reg;
        st.key_empty = (key_len_reg == '0);
        st.idx_last  = ((idx_reg + IW'(1)) == IW'(key_len_reg));
        st.idx_two   = (idx_reg == IW'(2));
        st.out_free  = !m_tvalid_reg || m_tready;
    end

    // Tokenizer state update
    always_comb begin
        pend_next      = pend_reg;
        key_len_next   = key_len_reg;
        in_key_next    = in_key_reg;
        data_open_next = data_open_reg;
        seen_next      = seen_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;

        if (cmd.pend_inc) begin
            pend_next = pend_reg + 2'd1;
        end else if (cmd.pend_dec) begin
            pend_next = pend_reg - 2'd1;
        end else if (cmd.pend_clr) begin
            pend_next = 2'd0;
        end

        if (app) begin
            if (!key_full) begin
                key_len_next = key_len_reg + LW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IW'(1);
        end

        if (cmd.emit && (cmd.sel == pdt_pkg::SEL_DATA_DELIM ||
                         cmd.sel == pdt_pkg::SEL_DATA_BYTE)) begin
            data_open_next = 1'b1;
        end

        if (cmd.key_open) begin
            in_key_next    = 1'b1;
            key_len_next   = '0;
            ovf_next       = 1'b0;
            data_open_next = 1'b0;
        end
        if (cmd.key_close) begin
            in_key_next  = 1'b0;
            key_len_next = '0;
            ovf_next     = 1'b0;
            seen_next    = 1'b1;
        end
        if (cmd.clear_all) begin
            pend_next      = 2'd0;
            key_len_next   = '0;
            in_key_next    = 1'b0;
            data_open_next = 1'b0;
            seen_next      = 1'b0;
            ovf_next       = 1'b0;
        end
    end

    // Result fields by selection
    always_comb begin
        o_kind  = pdt_pkg::KIND_DATA;
        o_value = 8'd0;
        o_new   = 1'b0;
        o_found = 1'b0;
        o_trunc = 1'b0;
        case (cmd.sel)
            pdt_pkg::SEL_DATA_DELIM: begin
                o_value = delim_reg;
                o_new   = !data_open_reg;
            end
            pdt_pkg::SEL_DATA_BYTE: begin
                o_value = byte_reg;
                o_new   = !data_open_reg;
            end
            pdt_pkg::SEL_KEY_BYTE: begin
                o_kind  = pdt_pkg::KIND_KEY;
                o_value = rdata_reg;
                o_new   = (idx_reg == '0);
                o_trunc = ovf_reg;
            end
            pdt_pkg::SEL_EMPTY: begin
                o_kind  = pdt_pkg::KIND_EMPTY;
                o_new   = 1'b1;
                o_trunc = ovf_reg;
            end
            pdt_pkg::SEL_DUMP_DELIM: begin
                o_value = delim_reg;
                o_new   = (idx_reg == '0);
                o_trunc = ovf_reg;
            end
            pdt_pkg::SEL_DUMP_KEY: begin
                o_value = rdata_reg;
                o_trunc = ovf_reg;
            end
            pdt_pkg::SEL_END: begin
                o_kind  = pdt_pkg::KIND_END;
                o_found = seen_reg;
            end
            default: begin
                o_kind = pdt_pkg::KIND_DATA;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg     <= pdt_pkg::DELIM_RESET;
            pend_reg      <= 2'd0;
            key_len_reg   <= '0;
            in_key_reg    <= 1'b0;
            data_open_reg <= 1'b0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                delim_reg <= cfg_wr_data;
            end
            pend_reg      <= pend_next;
            key_len_reg   <= key_len_next;
            in_key_reg    <= in_key_next;
            data_open_reg <= data_open_next;
            seen_reg      <= seen_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_tdata;
        end
        if (cmd.emit) begin
            kind_reg  <= o_kind;
            value_reg <= o_value;
            new_reg   <= o_new;
            last_reg  <= cmd.emit_last;
            found_reg <= o_found;
            trunc_reg <= o_trunc;
        end
    end

    // Keyword buffer; read address follows the next index so data is ready
    always_ff @(posedge aclk) begin
        if (app && !key_full) begin
            key_mem[key_len_reg[AW-1:0]] <= app_data;
        end
        rdata_reg <= key_mem[idx_next[AW-1:0]];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, trunc_reg, found_reg, new_reg, value_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== design/pdt_ctrl.sv =====
module pdt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pdt_pkg::status_t st,
    output pdt_pkg::cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_FLUSH  = 10'b0000000100,
        S_BODY   = 10'b0000001000,
        S_DUMPD  = 10'b0000010000,
        S_DUMPK  = 10'b0000100000,
        S_END    = 10'b0001000000,
        S_KEYOUT = 10'b0010000000,
        S_EMPTY  = 10'b0100000000,
        S_SPARE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = pdt_pkg::SEL_DATA_BYTE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (st.is_delim) begin
                    if (st.pend_two) begin
                        cmd.pend_clr = 1'b1;
                        if (st.in_key) begin
                            cmd.idx_clr = 1'b1;
                            state_next  = st.key_empty ? S_EMPTY : S_KEYOUT;
                        end else begin
                            cmd.key_open = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end else begin
                        cmd.pend_inc = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    state_next = st.pend_zero ? S_BODY : S_FLUSH;
                end
            end
            // Leftover delimiters, one per cycle; outside a keyword each waits for a free output register
            S_FLUSH: begin
                if (st.in_key) begin
                    cmd.append_delim = 1'b1;
                    cmd.pend_dec     = 1'b1;
                    if (st.pend_one) begin
                        state_next = S_BODY;
                    end
                end else if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.sel      = pdt_pkg::SEL_DATA_DELIM;
                    cmd.pend_dec = 1'b1;
                    if (st.pend_one) begin
                        state_next = S_BODY;
                    end
                end
            end
            S_BODY: begin
                if (st.is_zero) begin
                    if (st.in_key) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_DUMPD;
                    end else begin
                        state_next = S_END;
                    end
                end else if (st.in_key) begin
                    cmd.append_byte = 1'b1;
                    state_next      = S_IDLE;
                end else if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.sel       = pdt_pkg::SEL_DATA_BYTE;
                    state_next    = S_IDLE;
                end
            end
            // Unclosed keyword at end: three delimiters, then held bytes
            S_DUMPD: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = pdt_pkg::SEL_DUMP_DELIM;
                    if (st.idx_two) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = st.key_empty ? S_END : S_DUMPK;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_DUMPK: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = pdt_pkg::SEL_DUMP_KEY;
                    if (st.idx_last) begin
                        state_next = S_END;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_END: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.sel       = pdt_pkg::SEL_END;
                    cmd.clear_all = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            // Closed keyword: held bytes
            S_KEYOUT: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.sel       = pdt_pkg::SEL_KEY_BYTE;
                    cmd.emit_last = st.idx_last;
                    if (st.idx_last) begin
                        cmd.key_close = 1'b1;
                        state_next    = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.sel       = pdt_pkg::SEL_EMPTY;
                    cmd.key_close = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/placeholder_delimiter_tokenizer.sv =====
// Channel   Direction  Signals                    Contents
// input     in         s_tvalid/s_tready/s_tdata  in_byte
// result    out        m_tvalid/m_tready/m_tdata  value, new_item, found, truncated
//                      m_tuser, m_tlast           kind, run_last
// config    in         cfg_wr_en/cfg_wr_data      delimiter_byte
//
// An item passes accept and decode, a flush step per leftover delimiter and a
// step per result; held keyword bytes and the end byte also pass the body state.
// The single keyword-buffer read port sends a closed keyword's bytes one by one.
// s_tready is high only while the sequencer is idle.
// A stalled output register holds the sequencer where it is; nothing is lost.
// Reset is synchronous on aresetn low; the keyword buffer is not cleared.
module placeholder_delimiter_tokenizer #(
    parameter int KEY_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] value, [8] new_item, [9] found, [10] truncated
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    pdt_pkg::cmd_t    cmd;
    pdt_pkg::status_t st;

    pdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pdt_datapath #(
        .KEY_MAX (KEY_MAX)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .st          (st),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== design/pdt_checker.sv =====
module pdt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // End result closes its item and carries no byte, no new_item, no truncation
    a_end_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == pdt_pkg::KIND_END |->
            m_tlast && m_tdata[8:0] == 9'd0 && !m_tdata[10])
        else $error("end result malformed");

    // Empty keyword is a single, new, last result with value zero
    a_empty_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == pdt_pkg::KIND_EMPTY |->
            m_tlast && m_tdata[8] && m_tdata[7:0] == 8'd0)
        else $error("empty keyword result malformed");

    // found only appears on the end result
    a_found_only_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tuser == pdt_pkg::KIND_END)
        else $error("found outside end result");

    // One item at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back to back accept");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind placeholder_delimiter_tokenizer pdt_checker u_pdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/placeholder_delimiter_tokenizer_tb.sv =====
module placeholder_delimiter_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_MAX     = 32;
    localparam int STUCK_LIMIT = 3000;  // cycles with no handshake on either side
    localparam int LONG_STALL  = 400;   // receiver hold-off that backs the block up
    localparam int SETTLE      = 50;    // quiet cycles before a register write / at the end
    localparam int PRINT_MAX   = 100;

    typedef enum logic [1:0] {
        OUTSIDE,
        IN_KEYWORD,
        AFTER_KEYWORD
    } scan_mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       new_item;
        logic       run_last;
        logic       found;
        logic       truncated;
    } token_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Stimulus and expected results
    logic [7:0]  text_bytes[$];
    token_t      expected_tokens[$];
    token_t      step_buf[$];
    token_t      want;
    token_t      got;
    int unsigned mismatch_count = 0;
    int unsigned stuck_cycles = 0;
    int unsigned stall_requests = 0;
    int unsigned stall_served = 0;
    int unsigned tx_hold = 0;
    int unsigned rx_hold = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    // Tokenizer state as the testbench tracks it
    logic [7:0]  delim_q = pdt_pkg::DELIM_RESET;
    scan_mode_t  scan_mode = OUTSIDE;
    int unsigned pend_cnt = 0;
    logic [7:0]  held_key[KEY_MAX];
    int unsigned held_len = 0;
    bit          item_open = 1'b0;
    bit          kw_seen = 1'b0;
    bit          kw_trunc = 1'b0;

    placeholder_delimiter_tokenizer #(
        .KEY_MAX(KEY_MAX)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Tokenizer prediction
    // ---------------------------------------------------------------
    function automatic void add_token(input logic [1:0] kind, input logic [7:0] value,
                                      input logic nw, input logic fnd, input logic tr);
        token_t t;
        t.kind      = kind;
        t.value     = value;
        t.new_item  = nw;
        t.run_last  = 1'b0;
        t.found     = fnd;
        t.truncated = tr;
        step_buf.push_back(t);
    endfunction

    function automatic void emit_data(input logic [7:0] value);
        logic nw;
        nw = !item_open;
        item_open = 1'b1;
        add_token(pdt_pkg::KIND_DATA, value, nw, 1'b0, 1'b0);
    endfunction

    function automatic void hold_key_byte(input logic [7:0] value);
        if (held_len < KEY_MAX) begin
            held_key[held_len] = value;
            held_len++;
        end else begin
            kw_trunc = 1'b1;
        end
    endfunction

    function automatic void clear_scan();
        scan_mode = OUTSIDE;
        pend_cnt  = 0;
        held_len  = 0;
        item_open = 1'b0;
        kw_seen   = 1'b0;
        kw_trunc  = 1'b0;
    endfunction

    // Works out the results of one accepted byte and queues them
    function automatic void tokenize_byte(input logic [7:0] b);
        token_t t;
        int unsigned i;
        if (b != pdt_pkg::END_BYTE && b == delim_q) begin
            pend_cnt++;
            if (pend_cnt == 3) begin
                pend_cnt = 0;
                if (scan_mode == IN_KEYWORD) begin
                    // closing triple
                    if (held_len == 0)
                        add_token(pdt_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b0, kw_trunc);
                    for (i = 0; i < held_len; i++)
                        add_token(pdt_pkg::KIND_KEY, held_key[i], i == 0, 1'b0, kw_trunc);
                    kw_seen   = 1'b1;
                    held_len  = 0;
                    kw_trunc  = 1'b0;
                    scan_mode = AFTER_KEYWORD;
                end else begin
                    // opening triple ends the current data item
                    scan_mode = IN_KEYWORD;
                    held_len  = 0;
                    kw_trunc  = 1'b0;
                    item_open = 1'b0;
                end
            end
        end else begin
            // leftover delimiters go out with the value the register holds now
            for (i = 0; i < pend_cnt; i++) begin
                if (scan_mode == IN_KEYWORD)
                    hold_key_byte(delim_q);
                else
                    emit_data(delim_q);
            end
            pend_cnt = 0;
            if (b == pdt_pkg::END_BYTE) begin
                if (scan_mode == IN_KEYWORD) begin
                    // unclosed keyword comes back as plain data
                    for (i = 0; i < 3; i++)
                        add_token(pdt_pkg::KIND_DATA, delim_q, i == 0, 1'b0, kw_trunc);
                    for (i = 0; i < held_len; i++)
                        add_token(pdt_pkg::KIND_DATA, held_key[i], 1'b0, 1'b0, kw_trunc);
                end
                add_token(pdt_pkg::KIND_END, 8'h00, 1'b0, kw_seen, 1'b0);
                clear_scan();
            end else if (scan_mode == IN_KEYWORD) begin
                hold_key_byte(b);
            end else begin
                emit_data(b);
                scan_mode = OUTSIDE;
            end
        end
        for (i = 0; i < step_buf.size(); i++) begin
            t = step_buf[i];
            t.run_last = (i == step_buf.size() - 1);
            expected_tokens.push_back(t);
        end
        step_buf.delete();
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX)
            $display("%0t MISMATCH %s", $realtime, msg);
    endtask

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // Input driver
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_hold = 0;
        end else begin
            if ($urandom_range(0, 199) == 0)
                tx_calm = !tx_calm;
            if (!s_tvalid || s_tready) begin
                if (tx_hold > 0) begin
                    tx_hold--;
                    s_tvalid <= 1'b0;
                end else if (text_bytes.size() != 0) begin
                    s_tdata  <= text_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    tx_hold = idle_len(tx_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result receiver
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
            if (stall_served != stall_requests) begin
                stall_served = stall_requests;
                rx_hold = LONG_STALL;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_hold = idle_len(rx_calm);
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check results, predict from accepted bytes, watchdog
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind      = m_tuser;
                got.value     = m_tdata[7:0];
                got.new_item  = m_tdata[8];
                got.run_last  = m_tlast;
                got.found     = m_tdata[9];
                got.truncated = m_tdata[10];
                if (expected_tokens.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d value %02h",
                                            got.kind, got.value));
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                        flag_mismatch($sformatf(
                            "kind/value/new/last/found/trunc got %0d %02h %b %b %b %b want %0d %02h %b %b %b %b",
                            got.kind, got.value, got.new_item, got.run_last, got.found,
                            got.truncated, want.kind, want.value, want.new_item,
                            want.run_last, want.found, want.truncated));
                end
            end
            if (s_tvalid && s_tready)
                tokenize_byte(s_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles == STUCK_LIMIT) begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic logic [7:0] text_byte(input logic [7:0] d);
        logic [7:0] v;
        do
            v = 8'($urandom_range(1, 255));
        while (v == d);
        return v;
    endfunction

    function automatic void push_delims(input logic [7:0] d, input int unsigned n);
        repeat (n) text_bytes.push_back(d);
    endfunction

    // Plain text, now and then with one or two literal delimiters inside
    function automatic void add_text(input logic [7:0] d, input int unsigned n);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0)
                push_delims(d, $urandom_range(1, 2));
            text_bytes.push_back(text_byte(d));
        end
    endfunction

    function automatic void add_keyword(input logic [7:0] d, input int unsigned len,
                                        input bit closed);
        push_delims(d, 3);
        add_text(d, len);
        if (closed)
            push_delims(d, 3);
        else if ($urandom_range(0, 2) == 0)
            push_delims(d, $urandom_range(1, 2));
    endfunction

    // A well-formed string with random content, ended by the end byte
    function automatic void add_string(input logic [7:0] d);
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 2) == 0)
                add_keyword(d, ($urandom_range(0, 11) == 0) ? $urandom_range(33, 40)
                                                             : $urandom_range(0, 6), 1'b1);
            else
                add_text(d, $urandom_range(1, 6));
        end
        if ($urandom_range(0, 5) == 0)
            add_keyword(d, $urandom_range(0, 8), 1'b0);
        text_bytes.push_back(pdt_pkg::END_BYTE);
    endfunction

    function automatic void add_noise(input logic [7:0] d);
        int unsigned r;
        repeat ($urandom_range(4, 12)) begin
            r = $urandom_range(0, 9);
            if (r < 3)
                text_bytes.push_back(d);
            else if (r == 3)
                text_bytes.push_back(pdt_pkg::END_BYTE);
            else
                text_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // One phase of random strings; may stop mid-string so that the next
    // register value meets pending delimiters or an open keyword
    function automatic void fill_phase(input logic [7:0] d, input int unsigned target,
                                       input bit long_closed);
        int unsigned stop_at;
        stop_at = text_bytes.size() + target;
        add_text(d, 2);
        add_keyword(d, $urandom_range(34, 40), long_closed);
        text_bytes.push_back(pdt_pkg::END_BYTE);
        while (text_bytes.size() < stop_at) begin
            if ($urandom_range(0, 4) == 0)
                add_noise(d);
            else
                add_string(d);
        end
        case ($urandom_range(0, 2))
            0: begin
                add_text(d, $urandom_range(1, 3));
                push_delims(d, $urandom_range(1, 2));
            end
            1: begin
                add_keyword(d, $urandom_range(1, 3), 1'b0);
                push_delims(d, $urandom_range(1, 2));
            end
            default: ;
        endcase
    endfunction

    // Wait until everything is sent and answered, then let the block settle
    task automatic drain();
        while (text_bytes.size() != 0 || s_tvalid || expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_delimiter(input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        delim_q = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [7:0] settings[5];
        string      directed;
        int         i;

        clear_scan();
        delim_q = pdt_pkg::DELIM_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme bytes, keyword close, empty keyword, a literal
        // delimiter, and an unclosed keyword with two held delimiters
        text_bytes.push_back(8'h01);
        text_bytes.push_back(8'hFF);
        directed = "$$$k$$$$$$$$$$x";
        for (i = 0; i < directed.len(); i++)
            text_bytes.push_back(directed[i]);
        text_bytes.push_back(pdt_pkg::END_BYTE);
        directed = "$$$z$$";
        for (i = 0; i < directed.len(); i++)
            text_bytes.push_back(directed[i]);
        text_bytes.push_back(pdt_pkg::END_BYTE);
        drain();

        settings[0] = 8'hFF;
        settings[1] = 8'h01;
        settings[2] = 8'($urandom_range(1, 255));
        settings[3] = 8'($urandom_range(1, 255));
        settings[4] = pdt_pkg::DELIM_RESET;
        for (i = 0; i < 5; i++) begin
            write_delimiter(settings[i]);
            fill_phase(settings[i], 57, i[0]);
            // back up the block while the sender keeps offering
            if (i == 0)
                stall_requests++;
            drain();
        end

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
